// File: rtl/core/htp_pkg.sv
// ----------------------------------------------------------------------------
// htp_pkg
// Types and fixed constants shared by the heading turn PID controller.
// ----------------------------------------------------------------------------
package htp_pkg;

  // fixed point: angles in 1/64 degree, gains in Q0.24
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int GAIN_FRAC_BITS  = 24;

  localparam int HEADING_W = 15;
  localparam int DRIVE_W   = 16;
  localparam int MAG_W     = 15;
  localparam int GAIN_W    = 24;
  localparam int LIMIT_W   = 16;
  localparam int TICK_W    = 16;
  localparam int ERR_W     = 15;
  localparam int CHANGE_W  = 16;
  localparam int SUM_W     = 17;
  localparam int DIFF_W    = 17;

  // shared multiplier operands and product
  localparam int MUL_A_W = GAIN_FRAC_BITS + 2;
  localparam int MUL_B_W = SUM_W + 1;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [DIFF_W-1:0] FULL_TURN     = DIFF_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [DIFF_W-1:0] HALF_TURN     = DIFF_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ERR_W-1:0]  SETTLE_ERROR  = ERR_W'(2 << ANGLE_FRAC_BITS);
  localparam logic signed [CHANGE_W-1:0] SETTLE_CHANGE = CHANGE_W'(1 << ANGLE_FRAC_BITS);

  localparam logic signed [ACC_W-1:0] GAIN_ONE   = ACC_W'(64'sd1 << GAIN_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 << (GAIN_FRAC_BITS - 1));

  // opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 3'd7;

  typedef struct packed {
    logic                 opcode;
    logic [HEADING_W-1:0] heading;
  } in_word_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      move_done;
    logic                      timed_out;
  } out_word_t;

endpackage

// File: rtl/core/heading_turn_pid_top.sv
// ----------------------------------------------------------------------------
// heading_turn_pid_top
// PID heading controller for a two-sided drive with a clamped integrator,
// built around one shared signed multiplier under a small sequencer.
//
//   port group   direction   handshake         payload
//   in_*         input       valid / ready     in_word_t  (opcode, heading)
//   out_*        output      valid / ready     out_word_t (drives, flags)
//   cfg_*        input       write enable      index, 24-bit data
//
// a tick that runs the controller goes through the error and update steps, then four
// passes through the shared multiplier (p, i, d terms, accumulate and clamp, then
// drive scaling) and the round and output steps; a start word, a tick with no
// move open or a tick that ends the move goes from update straight to output
// one word at a time: in_ready is high only while the sequencer is idle
// the output register lets the next word enter while a result waits; a second
// waiting result holds the sequencer in its output step
// synchronous active-low reset restores the register defaults and closes any move
// ----------------------------------------------------------------------------
module heading_turn_pid_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  htp_pkg::in_word_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output htp_pkg::out_word_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [htp_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [htp_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import htp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_MP    = 4'd3;
  localparam logic [3:0] S_MI    = 4'd4;
  localparam logic [3:0] S_MD    = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_ROUND = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration
  logic [HEADING_W-1:0] target_r;
  logic [MAG_W-1:0]     max_drive_r;
  logic [MAG_W-1:0]     min_drive_r;
  logic [GAIN_W-1:0]    gain_p_r;
  logic [GAIN_W-1:0]    gain_i_r;
  logic [GAIN_W-1:0]    gain_d_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [TICK_W-1:0]    timeout_r;

  // controller state
  logic [3:0]                 state_r;
  logic [3:0]                 state_nxt;
  logic                       out_valid_r;
  logic                       active_r;
  logic signed [ERR_W-1:0]    prev_err_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [TICK_W-1:0]          tick_r;

  // datapath registers
  in_word_t                   word_r;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [CHANGE_W-1:0] change_r;
  logic signed [ACC_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [MUL_A_W-2:0]         mag_r;
  logic                       neg_r;
  out_word_t                  res_r;
  out_word_t                  out_data_r;

  // combinational
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   wrap1;
  logic signed [DIFF_W-1:0]   wrap2;
  logic signed [DIFF_W-1:0]   wrap3;
  logic signed [SUM_W:0]      sum_raw;
  logic signed [SUM_W:0]      lim_ext;
  logic signed [SUM_W:0]      sum_clip;
  logic signed [CHANGE_W-1:0] change;
  logic [TICK_W-1:0]          tick_nxt;
  logic                       settled;
  logic                       expired;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]    mul_p;
  logic signed [MUL_A_W-1:0]  acc_neg;
  logic signed [ACC_W-1:0]    rnd;
  logic [MAG_W-1:0]           scaled;
  logic [MAG_W-1:0]           mag_fin;
  logic signed [DRIVE_W-1:0]  drive;

  logic in_fire;
  logic out_fire;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && out_ready;
  assign out_free  = !out_valid_r || out_ready;

  // error wrap into (-180,180] degrees
  always_comb begin
    diff = $signed({2'b00, target_r}) - $signed({2'b00, word_r.heading});
    if (diff >= FULL_TURN) begin
      wrap1 = diff - FULL_TURN;
    end else if (diff <= -FULL_TURN) begin
      wrap1 = diff + FULL_TURN;
    end else begin
      wrap1 = diff;
    end
    wrap2 = (wrap1 < 0) ? wrap1 + FULL_TURN : wrap1;
    wrap3 = (wrap2 > HALF_TURN) ? wrap2 - FULL_TURN : wrap2;
  end

  // integrator, change and end-of-move tests from the registered error
  always_comb begin
    sum_raw = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(err_r);
    lim_ext = $signed({2'b00, limit_r});
    sum_clip = sum_raw;
    if (sum_clip > lim_ext) begin
      sum_clip = lim_ext;
    end
    if (sum_clip < -lim_ext) begin
      sum_clip = -lim_ext;
    end
    change   = CHANGE_W'(err_r) - CHANGE_W'(prev_err_r);
    tick_nxt = (tick_r == {TICK_W{1'b1}}) ? tick_r : tick_r + 1'b1;
    settled  = (err_r < SETTLE_ERROR) && (err_r > -SETTLE_ERROR)
               && (change < SETTLE_CHANGE) && (change > -SETTLE_CHANGE);
    expired  = (tick_nxt >= timeout_r);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MP: begin
        mul_a = $signed({2'b00, gain_p_r});
        mul_b = MUL_B_W'(err_r);
      end
      S_MI: begin
        mul_a = $signed({2'b00, gain_i_r});
        mul_b = MUL_B_W'(sum_r);
      end
      S_MD: begin
        mul_a = $signed({2'b00, gain_d_r});
        mul_b = MUL_B_W'(change_r);
      end
      S_SCALE: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = $signed({3'b000, max_drive_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // rounding, minimum drive and sign
  always_comb begin
    acc_neg = -acc_r[MUL_A_W-1:0];
    rnd     = prod_r + ROUND_HALF;
    scaled  = rnd[GAIN_FRAC_BITS +: MAG_W];
    mag_fin = (scaled != '0 && scaled < min_drive_r) ? min_drive_r : scaled;
    drive   = neg_r ? -$signed({1'b0, mag_fin}) : $signed({1'b0, mag_fin});
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = in_fire ? S_ERR : S_IDLE;
      S_ERR:   state_nxt = S_UPD;
      S_UPD: begin
        if (word_r.opcode == OP_TICK && active_r && !settled && !expired) begin
          state_nxt = S_MP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MP:    state_nxt = S_MI;
      S_MI:    state_nxt = S_MD;
      S_MD:    state_nxt = S_ACC;
      S_ACC:   state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_OUT;
      S_OUT:   state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      prev_err_r  <= '0;
      sum_r       <= '0;
      tick_r      <= '0;
      target_r    <= HEADING_W'(0);
      max_drive_r <= MAG_W'(32512);
      min_drive_r <= MAG_W'(2560);
      gain_p_r    <= GAIN_W'(16777);
      gain_i_r    <= GAIN_W'(35);
      gain_d_r    <= GAIN_W'(2252);
      limit_r     <= LIMIT_W'(6400);
      timeout_r   <= TICK_W'(500);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_UPD) begin
        if (word_r.opcode == OP_START) begin
          prev_err_r <= '0;
          sum_r      <= '0;
          tick_r     <= '0;
          active_r   <= !((err_r < SETTLE_ERROR) && (err_r > -SETTLE_ERROR));
        end else if (active_r) begin
          prev_err_r <= err_r;
          sum_r      <= sum_clip[SUM_W-1:0];
          tick_r     <= tick_nxt;
          if (settled || expired) begin
            active_r <= 1'b0;
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TARGET:  target_r    <= cfg_wdata[HEADING_W-1:0];
          REG_MAX:     max_drive_r <= cfg_wdata[MAG_W-1:0];
          REG_MIN:     min_drive_r <= cfg_wdata[MAG_W-1:0];
          REG_GAIN_P:  gain_p_r    <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:  gain_i_r    <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:  gain_d_r    <= cfg_wdata[GAIN_W-1:0];
          REG_LIMIT:   limit_r     <= cfg_wdata[LIMIT_W-1:0];
          REG_TIMEOUT: timeout_r   <= cfg_wdata[TICK_W-1:0];
          default:     target_r    <= target_r;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_data;
    end
    if (state_r == S_ERR) begin
      err_r <= wrap3[ERR_W-1:0];
    end
    if (state_r == S_UPD) begin
      change_r <= change;
      res_r.left_drive  <= '0;
      res_r.right_drive <= '0;
      res_r.timed_out   <= 1'b0;
      if (word_r.opcode == OP_START) begin
        res_r.move_done <= (err_r < SETTLE_ERROR) && (err_r > -SETTLE_ERROR);
      end else if (!active_r || settled) begin
        res_r.move_done <= 1'b1;
      end else begin
        res_r.move_done <= expired;
        res_r.timed_out <= expired;
      end
    end
    prod_r <= mul_p;
    unique case (state_r)
      S_MI:    acc_r <= prod_r;
      S_MD:    acc_r <= acc_r + prod_r;
      S_ACC:   acc_r <= acc_r + prod_r;
      default: acc_r <= acc_r;
    endcase
    // clamp the PID sum to +-1.0 and split into sign and magnitude
    if (state_r == S_CLAMP) begin
      neg_r <= acc_r < 0;
      if (acc_r > GAIN_ONE || acc_r < -GAIN_ONE) begin
        mag_r <= GAIN_ONE[MUL_A_W-2:0];
      end else if (acc_r < 0) begin
        mag_r <= acc_neg[MUL_A_W-2:0];
      end else begin
        mag_r <= acc_r[MUL_A_W-2:0];
      end
    end
    if (state_r == S_ROUND) begin
      res_r.left_drive  <= drive;
      res_r.right_drive <= -drive;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= res_r;
    end
  end

  a_drive_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.right_drive == -out_data_r.left_drive)
    else $error("right drive is not the negation of left drive");

  a_timeout_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.timed_out |-> out_data_r.move_done)
    else $error("timeout reported without end of move");

  a_done_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.move_done |-> out_data_r.left_drive == '0)
    else $error("drive nonzero on an ended move");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_ERR)
    else $error("accepted word did not start the sequencer");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result word not presented");

endmodule

// File: test/heading_turn_pid_checker.sv
// ----------------------------------------------------------------------------
// heading_turn_pid_checker
// Watches the word, result and register ports of the heading turn PID block.
// It keeps its own copy of the registers and controller state, works out the
// drive word each accepted input word should produce, and compares results in
// order, field by field.
// ----------------------------------------------------------------------------
module heading_turn_pid_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  htp_pkg::in_word_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  htp_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [htp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [htp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending_count
);
  import htp_pkg::*;

  localparam int TURN       = int'(FULL_TURN);
  localparam int HALF       = int'(HALF_TURN);
  localparam int NEAR_ERR   = int'(SETTLE_ERROR);
  localparam int NEAR_CHG   = int'(SETTLE_CHANGE);

  // register copies
  logic [HEADING_W-1:0] tgt_heading;
  logic [MAG_W-1:0]     max_drv;
  logic [MAG_W-1:0]     min_drv;
  logic [GAIN_W-1:0]    kp;
  logic [GAIN_W-1:0]    ki;
  logic [GAIN_W-1:0]    kd;
  logic [LIMIT_W-1:0]   sum_limit;
  logic [TICK_W-1:0]    tick_limit;

  // controller state
  logic                 move_open;
  int                   last_err;
  int                   err_acc;
  logic [TICK_W-1:0]    tick_cnt;

  out_word_t            expected_drives[$];

  function automatic int wrap_heading(int d);
    int r;
    r = d % TURN;
    if (r < 0) r += TURN;
    if (r > HALF) r -= TURN;
    return r;
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // advances the controller state by one word and returns the drive word
  function automatic out_word_t predict_drive(in_word_t w);
    int              err;
    int              change;
    int              drive;
    longint          total;
    longint          one;
    longint unsigned mag;
    logic            neg;
    out_word_t       res;
    err = wrap_heading(int'(tgt_heading) - int'(w.heading));
    res = '0;
    res.move_done = 1'b1;
    if (w.opcode == OP_START) begin
      last_err = 0;
      err_acc = 0;
      tick_cnt = '0;
      move_open = (abs_int(err) >= NEAR_ERR);
      res.move_done = !move_open;
    end else if (move_open) begin
      change = err - last_err;
      err_acc = err_acc + err;
      if (err_acc > int'(sum_limit)) err_acc = int'(sum_limit);
      if (err_acc < -int'(sum_limit)) err_acc = -int'(sum_limit);
      last_err = err;
      one = longint'(1) << GAIN_FRAC_BITS;
      total = longint'(kp) * err + longint'(ki) * err_acc + longint'(kd) * change;
      if (total > one) total = one;
      if (total < -one) total = -one;
      neg = (total < 0);
      mag = neg ? -total : total;
      // round half away from zero
      mag = (mag * max_drv + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
      if (mag != 0 && mag < min_drv) mag = min_drv;
      drive = neg ? -int'(mag) : int'(mag);
      if (tick_cnt != '1) tick_cnt++;
      if (abs_int(err) < NEAR_ERR && abs_int(change) < NEAR_CHG) begin
        move_open = 1'b0;
      end else if (tick_cnt >= tick_limit) begin
        move_open = 1'b0;
        res.timed_out = 1'b1;
      end else begin
        res.left_drive = DRIVE_W'(drive);
        res.right_drive = DRIVE_W'(-drive);
        res.move_done = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] drive check: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      tgt_heading = 15'd0;
      max_drv = 15'd32512;
      min_drv = 15'd2560;
      kp = 24'd16777;
      ki = 24'd35;
      kd = 24'd2252;
      sum_limit = 16'd6400;
      tick_limit = 16'd500;
      move_open = 1'b0;
      last_err = 0;
      err_acc = 0;
      tick_cnt = '0;
      expected_drives.delete();
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TARGET:  tgt_heading = cfg_wdata[HEADING_W-1:0];
          REG_MAX:     max_drv = cfg_wdata[MAG_W-1:0];
          REG_MIN:     min_drv = cfg_wdata[MAG_W-1:0];
          REG_GAIN_P:  kp = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:  ki = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:  kd = cfg_wdata[GAIN_W-1:0];
          REG_LIMIT:   sum_limit = cfg_wdata[LIMIT_W-1:0];
          REG_TIMEOUT: tick_limit = cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_drives.push_back(predict_drive(in_data));
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("result word with nothing pending", 1, 0);
        end else begin
          want = expected_drives.pop_front();
          if (out_data.left_drive !== want.left_drive)
            report_mismatch("left_drive", int'(out_data.left_drive), int'(want.left_drive));
          if (out_data.right_drive !== want.right_drive)
            report_mismatch("right_drive", int'(out_data.right_drive),
                            int'(want.right_drive));
          if (out_data.move_done !== want.move_done)
            report_mismatch("move_done", int'(out_data.move_done), int'(want.move_done));
          if (out_data.timed_out !== want.timed_out)
            report_mismatch("timed_out", int'(out_data.timed_out), int'(want.timed_out));
        end
      end
      pending_count <= expected_drives.size();
    end
  end

endmodule

// File: test/tb_heading_turn_pid_top.sv
// ----------------------------------------------------------------------------
// tb_heading_turn_pid_top
// Drives the heading turn PID block with start and tick words: a directed set
// over the field extremes and corner settings, then random moves that close
// in on the goal heading under random register settings, with random idling
// on both channels and one long result stall. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_heading_turn_pid_top;
  import htp_pkg::*;

  localparam int FULL         = int'(FULL_TURN);
  localparam int HALF         = int'(HALF_TURN);
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [HEADING_W-1:0] target;
    logic [MAG_W-1:0]     max_mag;
    logic [MAG_W-1:0]     min_mag;
    logic [GAIN_W-1:0]    kp;
    logic [GAIN_W-1:0]    ki;
    logic [GAIN_W-1:0]    kd;
    logic [LIMIT_W-1:0]   sum_lim;
    logic [TICK_W-1:0]    tick_lim;
  } steer_cfg_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending_count;
  int gap_pct     = 0;
  int sent        = 0;
  int goal        = 0;
  int cycle_count = 0;
  bit hold_req    = 1'b0;

  heading_turn_pid_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  heading_turn_pid_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** heading_turn_pid_top: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // valid stays up from one word to the next unless a gap is taken
  task automatic send_word(logic op, logic [HEADING_W-1:0] hd);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, heading: hd};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_settings(steer_cfg_t c);
    logic [CFG_ADDR_W-1:0] idx [8];
    logic [CFG_DATA_W-1:0] val [8];
    idx = '{REG_TARGET, REG_MAX, REG_MIN, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
            REG_LIMIT, REG_TIMEOUT};
    val = '{CFG_DATA_W'(c.target), CFG_DATA_W'(c.max_mag), CFG_DATA_W'(c.min_mag),
            CFG_DATA_W'(c.kp), CFG_DATA_W'(c.ki), CFG_DATA_W'(c.kd),
            CFG_DATA_W'(c.sum_lim), CFG_DATA_W'(c.tick_lim)};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    goal = int'(c.target) % FULL;
  endtask

  // folds into one turn, sometimes sent as the same angle one turn up
  function automatic logic [HEADING_W-1:0] heading_code(int p);
    p = ((p % FULL) + FULL) % FULL;
    if (p + FULL <= 32767 && $urandom_range(0, 5) == 0) p += FULL;
    return HEADING_W'(p);
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    return GAIN_W'($urandom) >> $urandom_range(0, 24);
  endfunction

  function automatic steer_cfg_t random_settings();
    steer_cfg_t c;
    c.target = ($urandom_range(0, 7) == 0) ? HEADING_W'($urandom_range(FULL, 32767))
                                            : HEADING_W'($urandom_range(0, FULL - 1));
    c.max_mag = ($urandom_range(0, 3) == 0) ? MAG_W'($urandom)
                                             : MAG_W'($urandom_range(0, 32512));
    case ($urandom_range(0, 3))
      0:       c.min_mag = '0;
      1:       c.min_mag = MAG_W'($urandom);
      default: c.min_mag = MAG_W'($urandom_range(0, 4000));
    endcase
    c.kp = random_gain();
    c.ki = random_gain();
    c.kd = random_gain();
    c.sum_lim = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom)
                                             : LIMIT_W'($urandom_range(0, 8000));
    case ($urandom_range(0, 7))
      0:       c.tick_lim = '0;
      1, 2:    c.tick_lim = TICK_W'($urandom);
      default: c.tick_lim = TICK_W'($urandom_range(1, 40));
    endcase
    return c;
  endfunction

  // start from a random heading, close in on the goal, then sit on it
  task automatic run_move(int steps);
    int pos;
    int miss;
    pos = $urandom_range(0, FULL - 1);
    send_word(OP_START, heading_code(pos));
    repeat (steps) begin
      miss = ((goal - pos) % FULL + FULL + HALF) % FULL - HALF;
      pos = pos + (miss * int'($urandom_range(1, 7))) / 8 + int'($urandom_range(0, 160)) - 80;
      send_word(OP_TICK, heading_code(pos));
    end
    repeat ($urandom_range(2, 4))
      send_word(OP_TICK, heading_code(goal + int'($urandom_range(0, 60)) - 30));
  endtask

  initial begin
    int stop_at;
    int next_cfg_at;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_TARGET;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 25;

    // register defaults, goal 0: no-move ticks, settle band edges, wrap edges
    send_word(OP_TICK, 15'd0);
    send_word(OP_START, 15'd0);
    send_word(OP_START, 15'd127);
    send_word(OP_START, 15'd22913);
    send_word(OP_START, 15'd128);
    send_word(OP_TICK, 15'd128);
    send_word(OP_TICK, 15'd32767);
    send_word(OP_TICK, 15'd11520);
    send_word(OP_TICK, 15'd11521);
    send_word(OP_TICK, 15'd23039);
    send_word(OP_TICK, 15'd0);
    send_word(OP_TICK, 15'd0);
    send_word(OP_TICK, 15'd5);
    wait_all_results();

    // goal beyond one turn, all gains full scale, no integral clamp
    load_settings('{15'd32767, 15'd32767, 15'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                    16'hFFFF, 16'hFFFF});
    send_word(OP_START, 15'd0);
    send_word(OP_TICK, 15'd0);
    send_word(OP_TICK, 15'd32767);
    send_word(OP_TICK, 15'd32767);
    wait_all_results();

    // zero timeout ends the move on its first tick
    load_settings('{15'd0, 15'd0, 15'd0, 24'd0, 24'd0, 24'd0, 16'd0, 16'd0});
    send_word(OP_START, 15'd5000);
    send_word(OP_TICK, 15'd5000);
    wait_all_results();

    // minimum above maximum, then timeout after two ticks
    load_settings('{15'd0, 15'd100, 15'd5000, 24'd16777, 24'd0, 24'd0, 16'd6400, 16'd2});
    send_word(OP_START, 15'd3000);
    send_word(OP_TICK, 15'd3000);
    send_word(OP_TICK, 15'd3000);
    wait_all_results();

    // zero gains: zero command stays zero despite the minimum
    load_settings('{15'd0, 15'd32512, 15'd2560, 24'd0, 24'd0, 24'd0, 16'd6400, 16'd500});
    send_word(OP_START, 15'd3000);
    send_word(OP_TICK, 15'd3000);
    send_word(OP_TICK, 15'd0);
    send_word(OP_TICK, 15'd0);
    wait_all_results();

    // long result stall while words keep coming, then a full drain
    load_settings('{15'd9000, 15'd32512, 15'd2560, 24'd16777, 24'd35, 24'd2252,
                    16'd6400, 16'd500});
    hold_req = 1'b1;
    run_move(10);
    wait_all_results();

    stop_at = sent + RANDOM_ITEMS;
    next_cfg_at = sent;
    while (sent < stop_at) begin
      if (sent >= next_cfg_at) begin
        wait_all_results();
        load_settings(random_settings());
        next_cfg_at = sent + $urandom_range(150, 300);
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      // no idling in the closing stretch
      if (sent + 150 >= stop_at) gap_pct = 0;
      case ($urandom_range(0, 9))
        0:       send_word(OP_TICK, HEADING_W'($urandom));
        1:       send_word(OP_START, heading_code(goal + int'($urandom_range(0, 400)) - 200));
        default: run_move($urandom_range(1, 20));
      endcase
    end
    wait_all_results();

    if (fail_count == 0)
      $display("** heading_turn_pid_top: PASSED **");
    else
      $display("** heading_turn_pid_top: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/htp_pkg.sv
rtl/core/heading_turn_pid_top.sv
test/heading_turn_pid_checker.sv
test/tb_heading_turn_pid_top.sv
